// ===== sv/zcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package zcr_pkg;

  // Block length limit, default value of the top-level parameter.
  localparam int unsigned MAX_SAMPLES_DEF = 524288;

  // Field widths fixed by the interface.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COH_W    = 18;
  localparam int unsigned COUNT_W  = 20;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned OUT_W    = 40;

  // Fraction bits of the squared ratio: 256 * S / sqrt(d) squared.
  localparam int unsigned FRAC2_W = 16;

  // Coherence saturates at 999.0 in Q.8.
  localparam logic [COH_W-1:0] COH_SAT = 18'd255744;

  // Configuration register indexes and reset values.
  localparam logic REG_THRESHOLD     = 1'b0;
  localparam logic REG_MIN_INTERVALS = 1'b1;

  localparam logic [COH_W-1:0]   THRESHOLD_RST     = 18'd1536;
  localparam logic [COUNT_W-1:0] MIN_INTERVALS_RST = 20'd100;

endpackage

`default_nettype wire

// ===== sv/zcr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module zcr_front
  import zcr_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  item_valid_i,
  output      logic                                  item_ready_o,
  input  wire logic [SAMPLE_W-1:0]                   sample_i,
  input  wire logic                                  last_i,
  output      logic                                  push_valid_o,
  input  wire logic                                  push_ready_i,
  // {square sum, interval sum, interval count}
  output      logic [4*$clog2(MAX_SAMPLES+1)-1:0]    push_data_o
);

  localparam int unsigned IW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned QW = 2 * IW;

  logic          prev_sign_q, prev_sign_d;
  logic          first_q, first_d;
  logic          seen_q, seen_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] last_idx_q, last_idx_d;
  logic [IW-1:0] count_q, count_d;
  logic [IW-1:0] total_q, total_d;
  logic [QW-1:0] square_q, square_d;

  logic          accept;
  logic          neg, pos, cur;
  logic [IW-1:0] interval;
  logic [QW-1:0] interval_sq;

  // Values after the current item, before the end-of-block clear.
  logic          up_prev, up_first, up_seen;
  logic [IW-1:0] up_idx, up_last_idx, up_count, up_total;
  logic [QW-1:0] up_square;

  assign item_ready_o = push_ready_i;
  assign accept       = item_valid_i & push_ready_i;

  assign neg = sample_i[SAMPLE_W-1];
  assign pos = !neg && (sample_i != '0);
  assign cur = pos ? 1'b1 : (neg ? 1'b0 : prev_sign_q);

  assign interval    = idx_q - last_idx_q;
  assign interval_sq = {{IW{1'b0}}, interval} * {{IW{1'b0}}, interval};

  always_comb begin
    up_prev     = prev_sign_q;
    up_first    = first_q;
    up_seen     = seen_q;
    up_idx      = idx_q;
    up_last_idx = last_idx_q;
    up_count    = count_q;
    up_total    = total_q;
    up_square   = square_q;
    if (first_q) begin
      // The first sample only sets the sign; zero counts as negative.
      up_prev  = pos;
      up_first = 1'b0;
      up_idx   = IW'(1);
    end else if (idx_q < IW'(MAX_SAMPLES)) begin
      if (cur != prev_sign_q) begin
        if (seen_q) begin
          up_count  = count_q + IW'(1);
          up_total  = total_q + interval;
          up_square = square_q + interval_sq;
        end
        up_seen     = 1'b1;
        up_last_idx = idx_q;
        up_prev     = cur;
      end
      up_idx = idx_q + IW'(1);
    end
  end

  always_comb begin
    prev_sign_d = prev_sign_q;
    first_d     = first_q;
    seen_d      = seen_q;
    idx_d       = idx_q;
    last_idx_d  = last_idx_q;
    count_d     = count_q;
    total_d     = total_q;
    square_d    = square_q;
    if (accept) begin
      if (last_i) begin
        prev_sign_d = 1'b0;
        first_d     = 1'b1;
        seen_d      = 1'b0;
        idx_d       = '0;
        last_idx_d  = '0;
        count_d     = '0;
        total_d     = '0;
        square_d    = '0;
      end else begin
        prev_sign_d = up_prev;
        first_d     = up_first;
        seen_d      = up_seen;
        idx_d       = up_idx;
        last_idx_d  = up_last_idx;
        count_d     = up_count;
        total_d     = up_total;
        square_d    = up_square;
      end
    end
  end

  assign push_valid_o = accept & last_i;
  assign push_data_o  = {up_square, up_total, up_count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sign_q <= 1'b0;
      first_q     <= 1'b1;
      seen_q      <= 1'b0;
      idx_q       <= '0;
      last_idx_q  <= '0;
      count_q     <= '0;
      total_q     <= '0;
      square_q    <= '0;
    end else begin
      prev_sign_q <= prev_sign_d;
      first_q     <= first_d;
      seen_q      <= seen_d;
      idx_q       <= idx_d;
      last_idx_q  <= last_idx_d;
      count_q     <= count_d;
      total_q     <= total_d;
      square_q    <= square_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/zcr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module zcr_queue
  import zcr_pkg::*;
#(
  parameter int unsigned DATA_W = 4 * $clog2(MAX_SAMPLES_DEF + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_valid_i,
  output      logic              wr_ready_o,
  input  wire logic [DATA_W-1:0] wr_data_i,
  output      logic              rd_valid_o,
  input  wire logic              rd_ready_i,
  output      logic [DATA_W-1:0] rd_data_o
);

  // Two entries, enough to hold one finished block while the next one is summed.
  logic [DATA_W-1:0] entry_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        fill_q, fill_d;
  logic              do_wr, do_rd;

  assign wr_ready_o = (fill_q != 2'd2);
  assign rd_valid_o = (fill_q != 2'd0);
  assign rd_data_o  = entry_q[rd_ptr_q];

  assign do_wr = wr_valid_i & wr_ready_o;
  assign do_rd = rd_valid_o & rd_ready_i;

  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_wr && !do_rd) begin
      fill_d = fill_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/zcr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module zcr_back
  import zcr_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [COH_W-1:0]                     threshold_i,
  input  wire logic [COUNT_W-1:0]                   min_intervals_i,
  input  wire logic                                 pop_valid_i,
  output      logic                                 pop_ready_o,
  // {square sum, interval sum, interval count}
  input  wire logic [4*$clog2(MAX_SAMPLES+1)-1:0]   pop_data_i,
  output      logic                                 res_valid_o,
  input  wire logic                                 res_ready_i,
  // coherence [17:0], coherent [18], interval_count [38:19], zero pad [39]
  output      logic [OUT_W-1:0]                     res_data_o
);

  localparam int unsigned IW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned QW = 2 * IW;
  localparam int unsigned PW = 3 * IW;          // n * Q and the variance term
  localparam int unsigned TW = QW + FRAC2_W;    // dividend S*S << 16, and quotient
  localparam int unsigned RW = TW / 2;          // square root of the quotient
  localparam int unsigned CW = $clog2(TW + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_MULHI = 3'd2;
  localparam logic [2:0] ST_DIFF  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_SQRT  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [IW-1:0]   n_q, s_q;
  logic [QW-1:0]   sq_sum_q;
  logic [QW-1:0]   s2_q;
  logic [QW-1:0]   plo_q;
  logic [PW-1:0]   nq_q;
  logic [PW-1:0]   d_q;
  logic [PW:0]     rem_q;
  logic [TW-1:0]   sh_q;
  logic [RW+1:0]   srem_q;
  logic [RW-1:0]   root_q;
  logic [COH_W-1:0] coh_q;

  logic [PW-1:0]   diff;
  logic            too_few;
  logic [PW:0]     rem_sh, rem_nx;
  logic            div_ge;
  logic [RW+3:0]   srem_sh, trial, srem_sub;
  logic            sqrt_ge;
  logic [31:0]     n_wide, root_wide;
  logic            coherent;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);

  assign diff    = nq_q - {{IW{1'b0}}, s2_q};
  assign n_wide  = 32'(n_q);
  assign too_few = (n_wide <= 32'(min_intervals_i));

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_q[PW-1:0], sh_q[TW-1]};
  assign div_ge = (rem_sh >= {1'b0, d_q});
  assign rem_nx = div_ge ? (rem_sh - {1'b0, d_q}) : rem_sh;

  // Integer square root, one root bit per cycle from two radicand bits.
  assign srem_sh  = {srem_q, sh_q[TW-1:TW-2]};
  assign trial    = {2'b00, root_q, 2'b01};
  assign sqrt_ge  = (srem_sh >= trial);
  assign srem_sub = srem_sh - trial;

  assign root_wide = 32'(root_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:   state_d = ST_MULHI;
      ST_MULHI: state_d = ST_DIFF;
      ST_DIFF: begin
        cnt_d = '0;
        if (too_few || diff == '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == CW'(TW - 1)) begin
          cnt_d   = '0;
          state_d = ST_SQRT;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_SQRT: begin
        if (cnt_q == CW'(RW - 1)) begin
          cnt_d   = '0;
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_OUT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          n_q      <= pop_data_i[IW-1:0];
          s_q      <= pop_data_i[2*IW-1:IW];
          sq_sum_q <= pop_data_i[4*IW-1:2*IW];
        end
      end
      ST_MUL: begin
        s2_q  <= {{IW{1'b0}}, s_q} * {{IW{1'b0}}, s_q};
        plo_q <= {{IW{1'b0}}, n_q} * {{IW{1'b0}}, sq_sum_q[IW-1:0]};
      end
      ST_MULHI: begin
        // The upper partial product lands IW bits up.
        nq_q <= {({{IW{1'b0}}, n_q} * {{IW{1'b0}}, sq_sum_q[QW-1:IW]}), {IW{1'b0}}}
                + {{IW{1'b0}}, plo_q};
      end
      ST_DIFF: begin
        d_q    <= diff;
        rem_q  <= '0;
        sh_q   <= {s2_q, {FRAC2_W{1'b0}}};
        srem_q <= '0;
        root_q <= '0;
        if (too_few) begin
          coh_q <= '0;
        end else if (diff == '0) begin
          coh_q <= COH_SAT;
        end
      end
      ST_DIV: begin
        rem_q <= rem_nx;
        sh_q  <= {sh_q[TW-2:0], div_ge};
      end
      ST_SQRT: begin
        srem_q <= sqrt_ge ? srem_sub[RW+1:0] : srem_sh[RW+1:0];
        root_q <= {root_q[RW-2:0], sqrt_ge};
        sh_q   <= {sh_q[TW-3:0], 2'b00};
        if (cnt_q == CW'(RW - 1)) begin
          // Final root bit is decided in this cycle.
          if ({root_wide[30:0], sqrt_ge} > 32'(COH_SAT)) begin
            coh_q <= COH_SAT;
          end else begin
            coh_q <= COH_W'({root_q[RW-2:0], sqrt_ge});
          end
        end
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign coherent   = (coh_q >= threshold_i);
  assign res_data_o = {1'b0, n_wide[COUNT_W-1:0], coherent, coh_q};

endmodule

`default_nettype wire

// ===== sv/zero_crossing_regularity_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one sample per cycle while the two-entry block queue has room.
// After the last sample of a block, its sums pass through the block queue, the
// multiply, upper multiply and difference states, then the bit-serial divider
// and square-root unit before the result is offered, skipping those two when the
// count is too low or the variance is zero; these two units bound the block rate.
// Reset is asynchronous and active low; it clears all sums, the queue and the
// result stage and loads the threshold 6.0 and minimum interval count 100.
module zero_crossing_regularity_unit
  import zcr_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_addr_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  // sample [15:0]
  input  wire logic [SAMPLE_W-1:0] s_axis_tdata_i,
  input  wire logic                s_axis_tlast_i,
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // coherence [17:0], coherent [18], interval_count [38:19], zero pad [39]
  output      logic [OUT_W-1:0]    m_axis_tdata_o
);

  localparam int unsigned IW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned QD = 4 * IW;

  logic [COH_W-1:0]   threshold_q;
  logic [COUNT_W-1:0] min_intervals_q;

  logic          push_valid, push_ready;
  logic [QD-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [QD-1:0] pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q     <= THRESHOLD_RST;
      min_intervals_q <= MIN_INTERVALS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_THRESHOLD:     threshold_q     <= cfg_wdata_i[COH_W-1:0];
        REG_MIN_INTERVALS: min_intervals_q <= cfg_wdata_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  zcr_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid_i),
    .item_ready_o (s_axis_tready_o),
    .sample_i     (s_axis_tdata_i),
    .last_i       (s_axis_tlast_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  zcr_queue #(
    .DATA_W(QD)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  zcr_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .threshold_i     (threshold_q),
    .min_intervals_i (min_intervals_q),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_data_i      (pop_data),
    .res_valid_o     (m_axis_tvalid_o),
    .res_ready_i     (m_axis_tready_i),
    .res_data_o      (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
